FILE: sv/assert_macros.svh
// Assertion macros used by the RTL of the scaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/bis_pkg.sv
// Shared constants and types of the bilinear image scaler.
package bis_pkg;

    // Parameter defaults.
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int PLANES_DEF     = 3;
    localparam int FRAC_BITS_DEF  = 12;

    // Field widths of the beats and registers.
    localparam int MODE_W     = 1;
    localparam int PLANE_W    = 2;
    localparam int COORD_W    = 9;
    localparam int PIX_W      = 8;
    localparam int STATUS_W   = 1;
    localparam int SIZE_W     = 10;
    localparam int SCALE_W    = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    // Q16 position arithmetic.
    localparam int Q_BITS   = 16;
    localparam int HALF_PIX = 32768;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd4;

    // Reset values of the registers.
    localparam logic [SIZE_W-1:0]  RST_SIZE  = 10'd512;
    localparam logic [SCALE_W-1:0] RST_SCALE = 26'd65536;

    // Beat codes.
    localparam logic [MODE_W-1:0]   MODE_STORE = 1'b0;
    localparam logic [MODE_W-1:0]   MODE_REQ   = 1'b1;
    localparam logic [STATUS_W-1:0] STAT_OK    = 1'b0;
    localparam logic [STATUS_W-1:0] STAT_ERR   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MAP,
        ST_READ,
        ST_FETCH,
        ST_HORZ,
        ST_RESULT
    } t_state;

endpackage

FILE: sv/bis_req_if.sv
// Input channel of the scaler: store and request beats.
interface bis_req_if;
    logic                          valid;
    logic                          ready;
    logic [bis_pkg::MODE_W-1:0]    mode;
    logic [bis_pkg::PLANE_W-1:0]   plane;
    logic [bis_pkg::COORD_W-1:0]   col;
    logic [bis_pkg::COORD_W-1:0]   row;
    logic [bis_pkg::PIX_W-1:0]     pixel_in;

    modport source (output valid, output mode, output plane, output col, output row,
                    output pixel_in, input ready);
    modport sink   (input valid, input mode, input plane, input col, input row,
                    input pixel_in, output ready);
endinterface

FILE: sv/bis_rsp_if.sv
// Output channel of the scaler: interpolated pixel beats.
interface bis_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bis_pkg::PIX_W-1:0]     pixel_out;
    logic [bis_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output pixel_out, output status, input ready);
    modport sink   (input valid, input pixel_out, input status, output ready);
endinterface

FILE: sv/bilinear_image_scaler.sv
// A store beat writes one source byte into the frame memory when its plane, column and row
// are in range, so stores stream at one per clock while the scaler is idle. A request beat
// maps the coordinates (multiply, then clamp), reads the four neighbours one at a time from
// the single-ported frame memory, drains the read, blends horizontally and blends vertically
// into the output register; it waits in the result state while that register is full and not
// taken, and the next beat is accepted once the state machine is back in idle. A rejected
// request (outside the destination or a missing plane) goes straight to the result state.
// The output register lets a new beat enter while a result waits to be taken. The frame memory
// needs no clearing pass after reset; only pixels that were stored may be read back.
`include "assert_macros.svh"

module bilinear_image_scaler #(
    parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF,
    parameter int PLANES     = bis_pkg::PLANES_DEF,
    parameter int FRAC_BITS  = bis_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    bis_req_if.sink                          i_req,
    bis_rsp_if.source                        o_rsp
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int PW    = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int AW    = PW + YW + XW;
    localparam int DEPTH = PLANES * (2 ** (YW + XW));
    localparam int SXW   = $clog2(MAX_WIDTH + 1);
    localparam int SYW   = $clog2(MAX_HEIGHT + 1);
    localparam int FW    = FRAC_BITS + 1;
    localparam int HW    = FRAC_BITS + bis_pkg::PIX_W;
    localparam int VW    = 2 * FRAC_BITS + bis_pkg::PIX_W + 1;
    localparam int PRODW = bis_pkg::SCALE_W + bis_pkg::COORD_W + 1;
    localparam int HALFW = PRODW - 1;
    localparam int IPW   = HALFW - bis_pkg::Q_BITS;
    localparam logic [FW-1:0] WONE = FW'(1) << FRAC_BITS;

    // Integer part of a mapped position, clamped to the first and the last neighbour pair.
    function automatic logic [31:0] axis_idx(input logic [HALFW-1:0] half,
                                             input logic [31:0] size);
        logic [HALFW-1:0] p;
        logic [IPW-1:0]   ip;
        p  = half - HALFW'(bis_pkg::HALF_PIX);
        ip = p[HALFW-1:bis_pkg::Q_BITS];
        if (half < HALFW'(bis_pkg::HALF_PIX)) begin
            return 32'd0;
        end else if (32'(ip) >= size - 32'd1) begin
            return size - 32'd2;
        end else begin
            return 32'(ip);
        end
    endfunction

    // Fraction of a mapped position; a negative position uses the first pixel and a
    // position past the last pair puts full weight on the edge pixel.
    function automatic logic [FW-1:0] axis_frac(input logic [HALFW-1:0] half,
                                                input logic [31:0] size);
        logic [HALFW-1:0] p;
        logic [IPW-1:0]   ip;
        p  = half - HALFW'(bis_pkg::HALF_PIX);
        ip = p[HALFW-1:bis_pkg::Q_BITS];
        if (half < HALFW'(bis_pkg::HALF_PIX)) begin
            return '0;
        end else if (32'(ip) >= size - 32'd1) begin
            return WONE;
        end else begin
            return FW'(p[bis_pkg::Q_BITS-1:bis_pkg::Q_BITS-FRAC_BITS]);
        end
    endfunction

    // Configuration registers.
    logic [bis_pkg::SIZE_W-1:0]  r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [bis_pkg::SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= bis_pkg::RST_SIZE;
            r_src_h <= bis_pkg::RST_SIZE;
            r_dst_w <= bis_pkg::RST_SIZE;
            r_dst_h <= bis_pkg::RST_SIZE;
            r_scale <= bis_pkg::RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bis_pkg::CFG_SRC_W: r_src_w <= i_cfg_wdata[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_SRC_H: r_src_h <= i_cfg_wdata[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_DST_W: r_dst_w <= i_cfg_wdata[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_DST_H: r_dst_h <= i_cfg_wdata[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_SCALE: r_scale <= i_cfg_wdata[bis_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Source sizes saturated to the range the frame memory supports.
    logic [SXW-1:0] sw;
    logic [SYW-1:0] sh;

    always_comb begin
        if (32'(r_src_w) < 32'd2) begin
            sw = SXW'(2);
        end else if (32'(r_src_w) > 32'(MAX_WIDTH)) begin
            sw = SXW'(MAX_WIDTH);
        end else begin
            sw = SXW'(r_src_w);
        end
        if (32'(r_src_h) < 32'd2) begin
            sh = SYW'(2);
        end else if (32'(r_src_h) > 32'(MAX_HEIGHT)) begin
            sh = SYW'(MAX_HEIGHT);
        end else begin
            sh = SYW'(r_src_h);
        end
    end

    // Control.
    bis_pkg::t_state r_state, n_state;
    logic            req_ready;
    logic            accept;
    logic            rd_en;
    logic            load_out;
    logic            req_err;
    logic            store_ok;
    logic [1:0]      r_rd_cnt;
    logic            r_cap_vld;
    logic [1:0]      r_cap_idx;
    logic            r_err;
    logic            r_out_vld;

    assign accept = i_req.valid && req_ready;

    assign req_err = (32'(i_req.plane) >= 32'(PLANES))
                  || ({1'b0, i_req.col} >= r_dst_w)
                  || ({1'b0, i_req.row} >= r_dst_h);

    assign store_ok = (32'(i_req.plane) < 32'(PLANES))
                   && (32'(i_req.col) < 32'(MAX_WIDTH))
                   && (32'(i_req.row) < 32'(MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bis_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        req_ready = 1'b0;
        rd_en     = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            bis_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid && i_req.mode == bis_pkg::MODE_REQ) begin
                    n_state = req_err ? bis_pkg::ST_RESULT : bis_pkg::ST_MUL;
                end
            end
            bis_pkg::ST_MUL:   n_state = bis_pkg::ST_MAP;
            bis_pkg::ST_MAP:   n_state = bis_pkg::ST_READ;
            bis_pkg::ST_READ: begin
                rd_en = 1'b1;
                if (r_rd_cnt == 2'd3) begin
                    n_state = bis_pkg::ST_FETCH;
                end
            end
            bis_pkg::ST_FETCH: n_state = bis_pkg::ST_HORZ;
            bis_pkg::ST_HORZ:  n_state = bis_pkg::ST_RESULT;
            bis_pkg::ST_RESULT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = bis_pkg::ST_IDLE;
                end
            end
            default: n_state = bis_pkg::ST_IDLE;
        endcase
    end

    assign i_req.ready = req_ready;

    // Request fields held for the duration of one request.
    logic [PW-1:0]                r_plane;
    logic [bis_pkg::COORD_W-1:0]  r_col, r_row;
    logic [31:0]                  plane_ext;

    assign plane_ext = 32'(i_req.plane);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plane <= plane_ext[PW-1:0];
            r_col   <= i_req.col;
            r_row   <= i_req.row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (accept) begin
            r_err <= req_err;
        end
    end

    // Coordinate mapping: the product is registered in the multiply state and clamped in the map state.
    logic [PRODW-1:0] prod_x, prod_y;
    logic [HALFW-1:0] r_half_x, r_half_y;
    logic [31:0]      left_full, top_full;
    logic [XW-1:0]    r_left;
    logic [YW-1:0]    r_top;
    logic [FW-1:0]    r_fx, r_fy;

    assign prod_x = PRODW'(r_scale) * PRODW'({r_col, 1'b1});
    assign prod_y = PRODW'(r_scale) * PRODW'({r_row, 1'b1});

    assign left_full = axis_idx(r_half_x, 32'(sw));
    assign top_full  = axis_idx(r_half_y, 32'(sh));

    always_ff @(posedge i_clk) begin
        if (r_state == bis_pkg::ST_MUL) begin
            r_half_x <= prod_x[PRODW-1:1];
            r_half_y <= prod_y[PRODW-1:1];
        end
        if (r_state == bis_pkg::ST_MAP) begin
            r_left <= left_full[XW-1:0];
            r_top  <= top_full[YW-1:0];
            r_fx   <= axis_frac(r_half_x, 32'(sw));
            r_fy   <= axis_frac(r_half_y, 32'(sh));
        end
    end

    // Frame memory. Writes happen only in idle and reads only in the read state, so the
    // state machine keeps the two from meeting on the single port.
    logic [bis_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [bis_pkg::PIX_W-1:0] r_mem_q;
    logic [AW-1:0]             wr_addr, rd_addr;
    logic [31:0]               wr_col, wr_row;
    logic                      mem_we;
    logic [XW-1:0]             rd_x;
    logic [YW-1:0]             rd_y;

    assign wr_col  = 32'(i_req.col);
    assign wr_row  = 32'(i_req.row);
    assign wr_addr = {plane_ext[PW-1:0], wr_row[YW-1:0], wr_col[XW-1:0]};
    assign mem_we  = accept && i_req.mode == bis_pkg::MODE_STORE && store_ok;

    // Neighbour order: top-left, top-right, bottom-left, bottom-right.
    assign rd_x    = r_left + XW'(r_rd_cnt[0]);
    assign rd_y    = r_top + YW'(r_rd_cnt[1]);
    assign rd_addr = {r_plane, rd_y, rd_x};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_req.pixel_in;
        end else if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt  <= 2'd0;
            r_cap_vld <= 1'b0;
            r_cap_idx <= 2'd0;
        end else begin
            r_rd_cnt  <= rd_en ? r_rd_cnt + 2'd1 : 2'd0;
            r_cap_vld <= rd_en;
            r_cap_idx <= r_rd_cnt;
        end
    end

    logic [bis_pkg::PIX_W-1:0] r_pix [4];

    always_ff @(posedge i_clk) begin
        if (r_cap_vld) begin
            r_pix[r_cap_idx] <= r_mem_q;
        end
    end

    // Horizontal blend of both rows, registered before the vertical blend.
    logic [FW-1:0] wx0, wy0;
    logic [HW-1:0] h_top, h_bot, r_h_top, r_h_bot;
    logic [VW-1:0] v_sum;

    assign wx0   = WONE - r_fx;
    assign wy0   = WONE - r_fy;
    assign h_top = HW'(wx0) * HW'(r_pix[0]) + HW'(r_fx) * HW'(r_pix[1]);
    assign h_bot = HW'(wx0) * HW'(r_pix[2]) + HW'(r_fx) * HW'(r_pix[3]);
    assign v_sum = VW'(wy0) * VW'(r_h_top) + VW'(r_fy) * VW'(r_h_bot);

    always_ff @(posedge i_clk) begin
        if (r_state == bis_pkg::ST_HORZ) begin
            r_h_top <= h_top;
            r_h_bot <= h_bot;
        end
    end

    // Output register; the vertical blend lands here directly.
    logic [bis_pkg::PIX_W-1:0]    r_pix_out;
    logic [bis_pkg::STATUS_W-1:0] r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_pix_out <= r_err ? '0 : v_sum[2*FRAC_BITS+bis_pkg::PIX_W-1:2*FRAC_BITS];
            r_status  <= r_err ? bis_pkg::STAT_ERR : bis_pkg::STAT_OK;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.pixel_out = r_pix_out;
    assign o_rsp.status    = r_status;

    logic in_read, frac_ok, nbr_ok, cap_ok, done_ok;

    assign in_read = r_state == bis_pkg::ST_READ;
    assign frac_ok = (r_fx <= WONE) && (r_fy <= WONE);
    assign nbr_ok  = (32'(r_left) + 32'd2 <= 32'(sw)) && (32'(r_top) + 32'd2 <= 32'(sh));
    assign cap_ok  = (r_state == bis_pkg::ST_READ) || (r_state == bis_pkg::ST_FETCH);
    assign done_ok = r_out_vld && (r_state == bis_pkg::ST_IDLE);

    `ASSERT_IMP(a_frac_range, i_clk, i_rst_n, in_read, frac_ok)
    `ASSERT_IMP(a_nbr_inside, i_clk, i_rst_n, in_read, nbr_ok)
    `ASSERT_IMP(a_cap_window, i_clk, i_rst_n, r_cap_vld, cap_ok)
    `ASSERT_NXT(a_result_load, i_clk, i_rst_n, load_out, done_ok)

endmodule
